[design/mbm_pkg.sv]
package mbm_pkg;

    // Default number of vertices on each side.
    localparam int MAX_SIDE_DEF = 256;

    // Widths fixed by the request and result fields.
    localparam int IDX_W = 8;
    localparam int CNT_W = 9;

    // Request type codes.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_LEFT_COUNT  = 1'b0;
    localparam logic CFG_RIGHT_COUNT = 1'b1;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_NEXTU = 7'b0000100,
        ST_RD    = 7'b0001000,
        ST_EV    = 7'b0010000,
        ST_POP   = 7'b0100000,
        ST_UNW   = 7'b1000000
    } mbm_state_t;

endpackage

[design/mbm_if.sv]
interface mbm_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [mbm_pkg::IDX_W-1:0] left_index;
    logic [mbm_pkg::IDX_W-1:0] right_index;

    modport source (output valid, req_type, left_index, right_index, input ready);
    modport sink   (input valid, req_type, left_index, right_index, output ready);
endinterface

interface mbm_res_if;
    logic                      valid;
    logic                      ready;
    logic [mbm_pkg::CNT_W-1:0] matched_count;
    logic                      bad_pair_seen;

    modport source (output valid, matched_count, bad_pair_seen, input ready);
    modport sink   (input valid, matched_count, bad_pair_seen, output ready);
endinterface

[design/max_bipartite_matching.sv]
// Maximum bipartite matching by augmenting paths. An add request stores one
// allowed (left, right) pair; a pair outside the configured counts is
// dropped and raises bad_pair_seen. A solve request runs one depth-first
// augmenting search per left vertex, with an explicit stack in memory, and
// returns the matching size. The search is driven by one scan step that
// tests a single right vertex at a time (adjacency and partner memory reads
// in ST_RD, then the decision in ST_EV); a push is made in the decision
// itself, a pop passes through ST_POP and each level of a path flip through
// ST_UNW. One search can hold a frame for every left vertex and each frame
// scans up to right_count vertices. After each solve, and after reset,
// the adjacency store is swept clean one word a cycle over its words,
// 2^(VW + WB) of them with VW = ceil(log2(MAX_SIDE)) row bits and WB =
// ceil(log2(ceil(MAX_SIDE/64))) slice bits, each at least one (1024 at the
// default); no request is taken during the sweep.
// Configuration writes are taken at any time but should only be made while
// the block is idle.
module max_bipartite_matching #(
    parameter int MAX_SIDE = mbm_pkg::MAX_SIDE_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [mbm_pkg::CNT_W-1:0] cfg_wdata,
    mbm_req_if.sink                   req,
    mbm_res_if.source                 res
);

    localparam int VW   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW   = $clog2(MAX_SIDE + 1);
    localparam int WPR  = (MAX_SIDE + 63) / 64;
    localparam int WB   = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int AAW  = VW + WB;
    localparam int SW   = $clog2(MAX_SIDE + 1);
    localparam int DW   = $clog2(MAX_SIDE + 2);
    localparam int CMPW = (CW > mbm_pkg::CNT_W) ? CW : mbm_pkg::CNT_W;
    localparam int XW   = CW + WB + 6;
    localparam int XIW  = mbm_pkg::IDX_W + WB + 6;
    localparam int SEW  = VW + CW + VW;
    localparam logic [CMPW-1:0] MAXV = CMPW'(MAX_SIDE);

    mbm_pkg::mbm_state_t state_reg, state_next;

    logic [mbm_pkg::CNT_W-1:0] left_count_reg, right_count_reg;
    logic [AAW-1:0]            clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]             u_reg, u_next;
    logic [CW-1:0]             match_reg, match_next;
    logic                      bad_reg, bad_next;
    logic [VW-1:0]             top_l_reg, top_l_next;
    logic [CW-1:0]             top_r_reg, top_r_next;
    logic [DW-1:0]             depth_reg, depth_next;
    logic [SW-1:0]             unw_reg, unw_next;
    logic [MAX_SIDE-1:0]       visited_reg, visited_next;
    logic [MAX_SIDE-1:0]       pvalid_reg, pvalid_next;
    logic                      out_valid_reg, out_valid_next;
    logic [mbm_pkg::CNT_W-1:0] out_count_reg, out_count_next;
    logic                      out_bad_reg, out_bad_next;

    logic [CMPW-1:0] lc_full, rc_full, lidx_x, ridx_c;
    logic [CW-1:0]   lc, rc;
    logic [XIW-1:0]  ridx_x;
    logic [XW-1:0]   top_r_x;
    logic            accept;

    logic            adj_clr_en, adj_set_en;
    logic [AAW-1:0]  adj_set_addr, adj_rd_addr;
    logic [63:0]     adj_rdata;

    logic            p_we;
    logic [VW-1:0]   p_waddr, p_wdata, p_rdata;

    logic            s_we;
    logic [SW-1:0]   s_waddr, s_raddr;
    logic [SEW-1:0]  s_wdata, s_rdata;
    logic [VW-1:0]   s_left, s_right;
    logic [CW-1:0]   s_pos;

    // Counts above MAX_SIDE act as MAX_SIDE.
    assign lc_full = CMPW'(left_count_reg);
    assign rc_full = CMPW'(right_count_reg);
    assign lc      = (lc_full > MAXV) ? MAXV[CW-1:0] : lc_full[CW-1:0];
    assign rc      = (rc_full > MAXV) ? MAXV[CW-1:0] : rc_full[CW-1:0];

    assign lidx_x  = CMPW'(req.left_index);
    assign ridx_c  = CMPW'(req.right_index);
    assign ridx_x  = XIW'(req.right_index);
    assign top_r_x = XW'(top_r_reg);

    assign s_left  = s_rdata[SEW-1 -: VW];
    assign s_pos   = s_rdata[VW + CW - 1 -: CW];
    assign s_right = s_rdata[VW-1:0];

    assign req.ready         = (state_reg == mbm_pkg::ST_IDLE) && !out_valid_reg;
    assign accept            = req.valid && req.ready;
    assign res.valid         = out_valid_reg;
    assign res.matched_count = out_count_reg;
    assign res.bad_pair_seen = out_bad_reg;

    // Adjacency store addressing.
    assign adj_set_addr = {lidx_x[VW-1:0], ridx_x[WB+5:6]};
    assign adj_rd_addr  = {top_l_reg, top_r_x[WB+5:6]};

    mbm_adj #(
        .AW (AAW)
    ) u_adj (
        .clk      (clk),
        .clr_en   (adj_clr_en),
        .clr_addr (clr_cnt_reg),
        .set_en   (adj_set_en),
        .set_addr (adj_set_addr),
        .set_bit  (ridx_x[5:0]),
        .rd_addr  (adj_rd_addr),
        .rd_data  (adj_rdata)
    );

    mbm_ram #(
        .W     (VW),
        .AW    (VW),
        .DEPTH (MAX_SIDE)
    ) u_partner (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (top_r_reg[VW-1:0]),
        .rdata (p_rdata)
    );

    mbm_ram #(
        .W     (SEW),
        .AW    (SW),
        .DEPTH (MAX_SIDE + 1)
    ) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Sequencer for loading, the augmenting searches and the clear sweep.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        u_next         = u_reg;
        match_next     = match_reg;
        bad_next       = bad_reg;
        top_l_next     = top_l_reg;
        top_r_next     = top_r_reg;
        depth_next     = depth_reg;
        unw_next       = unw_reg;
        visited_next   = visited_reg;
        pvalid_next    = pvalid_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_count_next = out_count_reg;
        out_bad_next   = out_bad_reg;
        adj_clr_en     = 1'b0;
        adj_set_en     = 1'b0;
        p_we           = 1'b0;
        p_waddr        = top_r_reg[VW-1:0];
        p_wdata        = top_l_reg;
        s_we           = 1'b0;
        s_waddr        = SW'(depth_reg - DW'(1));
        s_wdata        = {top_l_reg, top_r_reg + CW'(1), top_r_reg[VW-1:0]};
        s_raddr        = SW'(depth_reg - DW'(2));

        case (state_reg)
            mbm_pkg::ST_CLEAR:
            begin
                adj_clr_en   = 1'b1;
                clr_cnt_next = clr_cnt_reg + AAW'(1);
                if (&clr_cnt_reg)
                begin
                    state_next = mbm_pkg::ST_IDLE;
                end
            end

            mbm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.req_type == mbm_pkg::REQ_ADD)
                    begin
                        if (lidx_x >= CMPW'(lc) || ridx_c >= CMPW'(rc))
                        begin
                            bad_next = 1'b1;
                        end
                        else
                        begin
                            adj_set_en = 1'b1;
                        end
                    end
                    else
                    begin
                        pvalid_next = '0;
                        match_next  = '0;
                        u_next      = '0;
                        state_next  = mbm_pkg::ST_NEXTU;
                    end
                end
            end

            mbm_pkg::ST_NEXTU:
            begin
                if (u_reg == lc)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = mbm_pkg::CNT_W'(CMPW'(match_reg));
                    out_bad_next   = bad_reg;
                    bad_next       = 1'b0;
                    match_next     = '0;
                    clr_cnt_next   = '0;
                    state_next     = mbm_pkg::ST_CLEAR;
                end
                else
                begin
                    visited_next = '0;
                    top_l_next   = u_reg[VW-1:0];
                    top_r_next   = '0;
                    depth_next   = DW'(1);
                    state_next   = mbm_pkg::ST_RD;
                end
            end

            mbm_pkg::ST_RD:
            begin
                if (top_r_reg == rc)
                begin
                    // Frame exhausted: pop it.
                    depth_next = depth_reg - DW'(1);
                    if (depth_reg == DW'(1))
                    begin
                        u_next     = u_reg + CW'(1);
                        state_next = mbm_pkg::ST_NEXTU;
                    end
                    else
                    begin
                        state_next = mbm_pkg::ST_POP;
                    end
                end
                else
                begin
                    state_next = mbm_pkg::ST_EV;
                end
            end

            mbm_pkg::ST_EV:
            begin
                if (!adj_rdata[top_r_x[5:0]] || visited_reg[top_r_reg[VW-1:0]])
                begin
                    top_r_next = top_r_reg + CW'(1);
                    state_next = mbm_pkg::ST_RD;
                end
                else
                begin
                    visited_next[top_r_reg[VW-1:0]] = 1'b1;
                    if (!pvalid_reg[top_r_reg[VW-1:0]])
                    begin
                        // Free right vertex: flip the path back to the root.
                        p_we        = 1'b1;
                        pvalid_next[top_r_reg[VW-1:0]] = 1'b1;
                        match_next  = match_reg + CW'(1);
                        if (depth_reg == DW'(1))
                        begin
                            u_next     = u_reg + CW'(1);
                            state_next = mbm_pkg::ST_NEXTU;
                        end
                        else
                        begin
                            unw_next   = SW'(depth_reg - DW'(2));
                            state_next = mbm_pkg::ST_UNW;
                        end
                    end
                    else if (CW'(p_rdata) < lc && depth_reg <= DW'(MAX_SIDE))
                    begin
                        // Descend into the current partner's frame.
                        s_we       = 1'b1;
                        top_l_next = p_rdata;
                        top_r_next = '0;
                        depth_next = depth_reg + DW'(1);
                        state_next = mbm_pkg::ST_RD;
                    end
                    else
                    begin
                        top_r_next = top_r_reg + CW'(1);
                        state_next = mbm_pkg::ST_RD;
                    end
                end
            end

            mbm_pkg::ST_POP:
            begin
                top_l_next = s_left;
                top_r_next = s_pos;
                state_next = mbm_pkg::ST_RD;
            end

            mbm_pkg::ST_UNW:
            begin
                p_we    = 1'b1;
                p_waddr = s_right;
                p_wdata = s_left;
                pvalid_next[s_right] = 1'b1;
                s_raddr = unw_reg - SW'(1);
                if (unw_reg == '0)
                begin
                    u_next     = u_reg + CW'(1);
                    state_next = mbm_pkg::ST_NEXTU;
                end
                else
                begin
                    unw_next = unw_reg - SW'(1);
                end
            end

            default:
            begin
                state_next = mbm_pkg::ST_CLEAR;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_count_reg  <= '0;
            right_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == mbm_pkg::CFG_LEFT_COUNT)
            begin
                left_count_reg <= cfg_wdata;
            end
            else
            begin
                right_count_reg <= cfg_wdata;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mbm_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            u_reg         <= '0;
            match_reg     <= '0;
            bad_reg       <= 1'b0;
            depth_reg     <= '0;
            unw_reg       <= '0;
            visited_reg   <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            u_reg         <= u_next;
            match_reg     <= match_next;
            bad_reg       <= bad_next;
            depth_reg     <= depth_next;
            unw_reg       <= unw_next;
            visited_reg   <= visited_next;
            pvalid_reg    <= pvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_l_reg     <= top_l_next;
        top_r_reg     <= top_r_next;
        out_count_reg <= out_count_next;
        out_bad_reg   <= out_bad_next;
    end

    // The stack never grows past one frame per right vertex plus the root.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(MAX_SIDE + 1))
        else $error("search stack overflow");

    // Between searches, each left vertex tried has added at most one.
    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mbm_pkg::ST_NEXTU) |-> (match_reg <= u_reg))
        else $error("matching larger than vertices tried");

    // A result appears only at the end of a solve.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == mbm_pkg::ST_NEXTU))
        else $error("result without finished solve");

    // While a solve is running no request is taken.
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mbm_pkg::ST_IDLE) |-> !accept)
        else $error("request taken while busy");

endmodule

[design/mbm_adj.sv]
// Adjacency bit store: one 64-bit word per row slice, bit-set writes,
// whole-word clear writes and a registered read port.
module mbm_adj #(
    parameter int AW = 10
) (
    input  logic          clk,
    input  logic          clr_en,
    input  logic [AW-1:0] clr_addr,
    input  logic          set_en,
    input  logic [AW-1:0] set_addr,
    input  logic [5:0]    set_bit,
    input  logic [AW-1:0] rd_addr,
    output logic [63:0]   rd_data
);

    logic [63:0] mem [0:(1 << AW)-1];

    // Clear has priority; the sequencer never asks for both at once.
    always_ff @(posedge clk)
    begin
        if (clr_en)
        begin
            mem[clr_addr] <= '0;
        end
        else if (set_en)
        begin
            mem[set_addr][set_bit] <= 1'b1;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[design/mbm_ram.sv]
// Simple memory with one write port and one registered read port.
module mbm_ram #(
    parameter int W     = 8,
    parameter int AW    = 8,
    parameter int DEPTH = 256
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[tb/tb_top.sv]
module tb_top;

    // Margin over the post-solve clear sweep at the default size.
    localparam int SETTLE_CYCLES = 1200;
    localparam int STALL_LIMIT   = 2000000;
    localparam int SIDE          = mbm_pkg::MAX_SIDE_DEF;

    typedef struct packed {
        logic [mbm_pkg::CNT_W-1:0] matched_count;
        logic                      bad_pair_seen;
    } match_result_t;

    // Tracks the loaded graph and predicts the matching size of each solve.
    class matching_scoreboard;
        bit [SIDE-1:0]             adj [SIDE];
        bit                        bad;
        logic [mbm_pkg::CNT_W-1:0] left_count;
        logic [mbm_pkg::CNT_W-1:0] right_count;
        int                        partner [SIDE];
        bit                        seen [SIDE];
        int                        lc_eff;
        int                        rc_eff;
        match_result_t             pending [$];
        int                        errors;

        function void clear_graph();
            foreach (adj[i]) adj[i] = '0;
            bad = 1'b0;
        endfunction

        function bit augment(int u);
            for (int r = 0; r < rc_eff; r++)
            begin
                if (adj[u][r] && !seen[r])
                begin
                    seen[r] = 1'b1;
                    if (partner[r] < 0 || augment(partner[r]))
                    begin
                        partner[r] = u;
                        return 1'b1;
                    end
                end
            end
            return 1'b0;
        endfunction

        // Applies one accepted request; a solve queues its expected result.
        function void note_request(logic req_type, logic [mbm_pkg::IDX_W-1:0] l,
                                   logic [mbm_pkg::IDX_W-1:0] r);
            match_result_t exp_res;
            int total;
            lc_eff = (left_count > SIDE) ? SIDE : int'(left_count);
            rc_eff = (right_count > SIDE) ? SIDE : int'(right_count);
            if (req_type == mbm_pkg::REQ_ADD)
            begin
                if (int'(l) >= lc_eff || int'(r) >= rc_eff)
                    bad = 1'b1;
                else
                    adj[l][r] = 1'b1;
            end
            else
            begin
                total = 0;
                foreach (partner[i]) partner[i] = -1;
                for (int u = 0; u < lc_eff; u++)
                begin
                    foreach (seen[i]) seen[i] = 1'b0;
                    total += augment(u);
                end
                exp_res.matched_count = total[mbm_pkg::CNT_W-1:0];
                exp_res.bad_pair_seen = bad;
                pending.insert(pending.size(), exp_res);
                clear_graph();
            end
        endfunction

        // Compares one accepted result with the oldest expected one.
        function void check_result(logic [mbm_pkg::CNT_W-1:0] mc, logic bp);
            match_result_t exp_res;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result count=%0d bad=%0d", mc, bp);
                return;
            end
            exp_res = pending.pop_front();
            if (mc !== exp_res.matched_count || bp !== exp_res.bad_pair_seen)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result count=%0d bad=%0d, expected count=%0d bad=%0d",
                             mc, bp, exp_res.matched_count, exp_res.bad_pair_seen);
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic                      cfg_index;
    logic [mbm_pkg::CNT_W-1:0] cfg_wdata;
    bit                        quiet;
    int                        stall_cycles;
    int                        res_hold;

    mbm_req_if req_ch ();
    mbm_res_if res_ch ();

    matching_scoreboard sb;

    max_bipartite_matching dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Sends one request and waits for it to be accepted.
    task automatic send_request(logic t, logic [mbm_pkg::IDX_W-1:0] l,
                                logic [mbm_pkg::IDX_W-1:0] r);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= t;
        req_ch.left_index  <= l;
        req_ch.right_index <= r;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(t, l, r);
    endtask

    // Waits until every result has arrived and the clear sweep is over.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_counts(int lc, int rc);
        logic [mbm_pkg::CNT_W-1:0] lv;
        logic [mbm_pkg::CNT_W-1:0] rv;
        lv = lc[mbm_pkg::CNT_W-1:0];
        rv = rc[mbm_pkg::CNT_W-1:0];
        cfg_we    <= 1'b1;
        cfg_index <= mbm_pkg::CFG_LEFT_COUNT;
        cfg_wdata <= lv;
        @(posedge clk);
        cfg_index <= mbm_pkg::CFG_RIGHT_COUNT;
        cfg_wdata <= rv;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.left_count  = lv;
        sb.right_count = rv;
    endtask

    // One random graph: mostly in-range pairs, some noise, then a solve.
    task automatic random_set(int lc, int rc, int pairs);
        int lim_l;
        int lim_r;
        lim_l = (lc > SIDE) ? SIDE : lc;
        lim_r = (rc > SIDE) ? SIDE : rc;
        for (int i = 0; i < pairs; i++)
        begin
            if (lim_l == 0 || lim_r == 0 || $urandom_range(0, 9) == 0)
                send_request(mbm_pkg::REQ_ADD, mbm_pkg::IDX_W'($urandom_range(0, 255)),
                             mbm_pkg::IDX_W'($urandom_range(0, 255)));
            else
                send_request(mbm_pkg::REQ_ADD,
                             mbm_pkg::IDX_W'($urandom_range(0, lim_l - 1)),
                             mbm_pkg::IDX_W'($urandom_range(0, lim_r - 1)));
        end
        send_request(mbm_pkg::REQ_SOLVE, mbm_pkg::IDX_W'($urandom_range(0, 255)),
                     mbm_pkg::IDX_W'($urandom_range(0, 255)));
    endtask

    // Result side: random backpressure bursts, checking and the watchdog.
    always @(posedge clk)
    begin
        if (res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.matched_count, res_ch.bad_pair_seen);
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        if (res_hold > 0)
        begin
            res_hold     <= res_hold - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            res_hold     <= $urandom_range(0, 11);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // Stimulus sequence.
    initial
    begin
        int lc;
        int rc;
        int pairs;
        int sent;
        sb = new();
        sb.clear_graph();
        sb.left_count  = '0;
        sb.right_count = '0;
        quiet              = 1'b0;
        stall_cycles       = 0;
        res_hold           = 0;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = mbm_pkg::CFG_LEFT_COUNT;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = mbm_pkg::REQ_ADD;
        req_ch.left_index  = '0;
        req_ch.right_index = '0;
        res_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero counts: every pair is out of range.
        write_counts(0, 0);
        send_request(mbm_pkg::REQ_ADD, 0, 0);
        send_request(mbm_pkg::REQ_SOLVE, 0, 0);
        drain();

        // Full size, extreme indexes and a duplicate pair.
        write_counts(256, 256);
        send_request(mbm_pkg::REQ_ADD, 255, 255);
        send_request(mbm_pkg::REQ_ADD, 0, 0);
        send_request(mbm_pkg::REQ_ADD, 0, 0);
        send_request(mbm_pkg::REQ_ADD, 255, 0);
        send_request(mbm_pkg::REQ_SOLVE, 255, 255);
        drain();

        // Counts above the maximum act as the maximum.
        write_counts(511, 511);
        send_request(mbm_pkg::REQ_ADD, 255, 255);
        send_request(mbm_pkg::REQ_SOLVE, 0, 0);
        drain();

        // A chain that needs augmenting paths, plus one bad pair.
        write_counts(4, 4);
        send_request(mbm_pkg::REQ_ADD, 0, 0);
        send_request(mbm_pkg::REQ_ADD, 1, 0);
        send_request(mbm_pkg::REQ_ADD, 1, 1);
        send_request(mbm_pkg::REQ_ADD, 2, 1);
        send_request(mbm_pkg::REQ_ADD, 2, 2);
        send_request(mbm_pkg::REQ_ADD, 3, 2);
        send_request(mbm_pkg::REQ_ADD, 3, 3);
        send_request(mbm_pkg::REQ_ADD, 9, 1);
        send_request(mbm_pkg::REQ_SOLVE, 0, 0);
        drain();

        // Counts shrunk after loading hide pairs beyond them.
        write_counts(16, 16);
        send_request(mbm_pkg::REQ_ADD, 10, 10);
        send_request(mbm_pkg::REQ_ADD, 1, 1);
        drain();
        write_counts(2, 2);
        send_request(mbm_pkg::REQ_SOLVE, 0, 0);
        drain();

        // Random graphs: mostly small, a few at or beyond full size.
        sent = 0;
        while (sent < 1700)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    lc    = 256;
                    rc    = 256;
                    pairs = $urandom_range(5, 40);
                end
                1:
                begin
                    lc    = $urandom_range(257, 511);
                    rc    = $urandom_range(0, 8);
                    pairs = $urandom_range(3, 20);
                end
                2:
                begin
                    lc    = 0;
                    rc    = $urandom_range(0, 511);
                    pairs = $urandom_range(1, 6);
                end
                default:
                begin
                    lc    = $urandom_range(1, 16);
                    rc    = $urandom_range(1, 16);
                    pairs = $urandom_range(3, 40);
                end
            endcase
            if (sent > 1450)
                quiet = 1'b1;
            write_counts(lc, rc);
            random_set(lc, rc, pairs);
            sent += pairs + 1;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
